// ===== design/efat_pkg.sv =====
package efat_pkg;

  // Storage and field sizes.
  localparam int MAX_KEPT  = 16;
  localparam int TIME_BITS = 32;
  localparam int IN_W      = 32;
  localparam int MEAN_W    = 32;
  localparam int CNT_W     = 16;
  localparam int NK_W      = 5;
  localparam logic [NK_W-1:0] NK_RESET = NK_W'(16);

  // Derived widths.
  localparam int IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int K_W    = $clog2(MAX_KEPT + 1);
  localparam int KC_W   = (NK_W > K_W) ? NK_W : K_W;
  localparam int DIV_W  = K_W + 1;
  localparam int SUM_W  = TIME_BITS + $clog2(2 * MAX_KEPT);
  localparam int QUO_W  = (SUM_W > MEAN_W) ? SUM_W : MEAN_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  // Control of one list cell.
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV
  } state_e;

  // Operation codes.
  localparam logic OP_HIT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Input time reduced to the kept time width.
  function automatic logic [TIME_BITS-1:0] to_time(input logic [IN_W-1:0] a);
    logic [TIME_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < TIME_BITS; i++) begin
      if (i < IN_W) begin
        r[i] = a[i];
      end
    end
    return r;
  endfunction

endpackage

// ===== design/efat_cell.sv =====
module efat_cell
  import efat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_ctrl_t           ctrl_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  logic [TIME_BITS-1:0] prev_val_i,
  input  logic                 prev_valid_i,
  input  logic                 prev_ins_i,
  input  logic [TIME_BITS-1:0] next_val_i,
  input  logic                 next_valid_i,
  output logic [TIME_BITS-1:0] val_o,
  output logic                 valid_o,
  output logic                 ins_o
);

  logic [TIME_BITS-1:0] val_q, val_d;
  logic                 valid_q, valid_d;
  logic                 take;

  // A valid cell moves when the new time is below its own. An empty cell
  // fills only when its lower neighbor holds a time.
  always_comb begin
    ins_o   = valid_q && (time_i < val_q);
    take    = valid_q ? ins_o : prev_valid_i;
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      val_d   = next_val_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.ins && take) begin
      val_d   = prev_ins_i ? prev_val_i : time_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      val_q   <= val_d;
      valid_q <= valid_d;
    end
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

// ===== design/efat_div.sv =====
module efat_div
  import efat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [MEAN_W-1:0] quotient_o
);

  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    rem_sh;
  logic [DIV_W:0]    rem_sub;
  logic              ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_q, quo_q[QUO_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    ge      = rem_sh >= {1'b0, div_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    step_d  = step_q;
    done_d  = done_q;
    if (start_i) begin
      quo_d  = QUO_W'(dividend_i);
      rem_d  = '0;
      div_d  = divisor_i;
      step_d = STEP_W'(QUO_W);
      done_d = 1'b0;
    end else if (step_q != '0) begin
      quo_d  = {quo_q[QUO_W-2:0], ge};
      rem_d  = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      step_d = step_q - STEP_W'(1);
      done_d = (step_q == STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[MEAN_W-1:0];

endmodule

// ===== design/two_side_earliest_arrival_timer_core.sv =====
// Two-side earliest arrival timer.
// Input channel (in_valid_i / in_stall_o): each beat carries an opcode, a
// side and an arrival time. A hit beat inserts the time into the sorted list
// of its side; hits are taken one per cycle while no readout is under way,
// with no result. A readout beat gives one result beat on the output channel
// (out_valid_o / out_stall_i): the mean of the first num_kept entries of
// both lists, and the hit counts of both sides. The lists and counts are
// then empty. A readout shifts both cell rows out through the adder (which
// also clears them), then runs the bit-serial divider, then loads the output
// register. The input is stalled during that time. A result that waits in
// the output register does not block hits; a second readout waits for the
// slot. The configuration channel (cfg_valid_i / cfg_ready_o) writes
// num_kept and is always ready. Reset empties the lists, clears the counts
// and sets num_kept to 16.
module two_side_earliest_arrival_timer_core
  import efat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic              side_i,
  input  logic [IN_W-1:0]   arrival_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [MEAN_W-1:0] mean_time_o,
  output logic [CNT_W-1:0]  right_hits_o,
  output logic [CNT_W-1:0]  left_hits_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [NK_W-1:0]   cfg_data_i
);

  state_e state_q, state_d;

  logic [NK_W-1:0]   num_kept_q;
  logic [CNT_W-1:0]  rcnt_q, lcnt_q, rcnt_d, lcnt_d;
  logic [CNT_W-1:0]  rlat_q, llat_q;
  logic [K_W-1:0]    k_q, k_clamp;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SUM_W-1:0]  acc_q, acc_d, acc_sum, addend;
  logic              out_valid_q, out_load;
  logic [MEAN_W-1:0] mean_q;
  logic [CNT_W-1:0]  rh_q, lh_q;

  logic              acc_in, hit, rd, div_start, div_done;
  logic [MEAN_W-1:0] quotient;
  logic [TIME_BITS-1:0] t;
  cell_ctrl_t        rctrl, lctrl;

  logic [TIME_BITS-1:0] rval [MAX_KEPT+1];
  logic [TIME_BITS-1:0] lval [MAX_KEPT+1];
  logic                 rvld [MAX_KEPT+1];
  logic                 lvld [MAX_KEPT+1];
  logic                 rins [MAX_KEPT];
  logic                 lins [MAX_KEPT];

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_kept_q <= NK_RESET;
    end else if (cfg_valid_i) begin
      num_kept_q <= cfg_data_i;
    end
  end

  // Input handshake and decode.
  assign in_stall_o = (state_q != ST_IDLE);
  assign acc_in     = in_valid_i && !in_stall_o;
  assign hit        = acc_in && (opcode_i == OP_HIT);
  assign rd         = acc_in && (opcode_i == OP_READ);
  assign t          = to_time(arrival_time_i);

  // num_kept clamped to one up to MAX_KEPT.
  always_comb begin
    if (num_kept_q == '0) begin
      k_clamp = K_W'(1);
    end else if (KC_W'(num_kept_q) > KC_W'(MAX_KEPT)) begin
      k_clamp = K_W'(MAX_KEPT);
    end else begin
      k_clamp = K_W'(num_kept_q);
    end
  end

  // Cell controls: insert on a hit, shift toward cell zero while summing.
  always_comb begin
    rctrl.ins   = hit && side_i;
    rctrl.shift = (state_q == ST_SUM);
    lctrl.ins   = hit && !side_i;
    lctrl.shift = (state_q == ST_SUM);
  end

  // Rows of sorted cells, cell zero holds the earliest time.
  assign rval[MAX_KEPT] = '0;
  assign lval[MAX_KEPT] = '0;
  assign rvld[MAX_KEPT] = 1'b0;
  assign lvld[MAX_KEPT] = 1'b0;

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cells
    logic [TIME_BITS-1:0] rpv, lpv;
    logic                 rpvl, lpvl, rpi, lpi;

    if (i == 0) begin : g_first
      assign rpv  = '0;
      assign lpv  = '0;
      assign rpvl = 1'b1;
      assign lpvl = 1'b1;
      assign rpi  = 1'b0;
      assign lpi  = 1'b0;
    end else begin : g_rest
      assign rpv  = rval[i-1];
      assign lpv  = lval[i-1];
      assign rpvl = rvld[i-1];
      assign lpvl = lvld[i-1];
      assign rpi  = rins[i-1];
      assign lpi  = lins[i-1];
    end

    efat_cell u_rcell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (rctrl),
      .time_i       (t),
      .prev_val_i   (rpv),
      .prev_valid_i (rpvl),
      .prev_ins_i   (rpi),
      .next_val_i   (rval[i+1]),
      .next_valid_i (rvld[i+1]),
      .val_o        (rval[i]),
      .valid_o      (rvld[i]),
      .ins_o        (rins[i])
    );

    efat_cell u_lcell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lctrl),
      .time_i       (t),
      .prev_val_i   (lpv),
      .prev_valid_i (lpvl),
      .prev_ins_i   (lpi),
      .next_val_i   (lval[i+1]),
      .next_valid_i (lvld[i+1]),
      .val_o        (lval[i]),
      .valid_o      (lvld[i]),
      .ins_o        (lins[i])
    );
  end

  // Accumulate the head cells of both rows for the first k shifts.
  always_comb begin
    if (KC_W'(idx_q) < KC_W'(k_q)) begin
      addend = SUM_W'(rval[0]) + SUM_W'(lval[0]);
    end else begin
      addend = '0;
    end
    acc_sum = acc_q + addend;
  end

  // Hit counters, saturating.
  always_comb begin
    rcnt_d = rcnt_q;
    lcnt_d = lcnt_q;
    if (rd) begin
      rcnt_d = '0;
      lcnt_d = '0;
    end else if (hit && side_i && (rcnt_q != '1)) begin
      rcnt_d = rcnt_q + CNT_W'(1);
    end else if (hit && !side_i && (lcnt_q != '1)) begin
      lcnt_d = lcnt_q + CNT_W'(1);
    end
  end

  // Sequencer for the readout.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (rd) begin
          state_d = ST_SUM;
          idx_d   = '0;
          acc_d   = '0;
        end
      end
      ST_SUM: begin
        acc_d = acc_sum;
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(MAX_KEPT - 1)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && (!out_valid_q || !out_stall_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  efat_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_sum),
    .divisor_i  ({k_q, 1'b0}),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rcnt_q      <= '0;
      lcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
      lcnt_q  <= lcnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    acc_q <= acc_d;
    if (rd) begin
      rlat_q <= rcnt_q;
      llat_q <= lcnt_q;
      k_q    <= k_clamp;
    end
    if (out_load) begin
      mean_q <= quotient;
      rh_q   <= rlat_q;
      lh_q   <= llat_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_time_o  = mean_q;
  assign right_hits_o = rh_q;
  assign left_hits_o  = lh_q;

endmodule

// ===== sim/tb_two_side_earliest_arrival_timer_core.sv =====
module tb_two_side_earliest_arrival_timer_core
  import efat_pkg::*;
();

  localparam int  CLK_PERIOD     = 20;
  localparam int  RESET_CYCLES   = 5;
  // Covers a full readout, with a margin on top.
  localparam int  READOUT_SETTLE = 80;
  localparam int  MISMATCH_SHOWN = 10;
  localparam longint TIMEOUT_CYCLES = 200_000;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // Predictor of the two sorted lists, the hit counts and the mean readout.
  class arrival_mean_board;
    logic [TIME_BITS-1:0] earliest[2][MAX_KEPT];
    logic [CNT_W-1:0]     hits[2];
    logic [NK_W-1:0]      num_kept;
    logic [MEAN_W-1:0]    want_mean[$];
    logic [CNT_W-1:0]     want_right[$];
    logic [CNT_W-1:0]     want_left[$];
    int                   mismatches;

    function new();
      clear_lists();
      num_kept   = NK_RESET;
      mismatches = 0;
    endfunction

    function void clear_lists();
      for (int s = 0; s < 2; s++) begin
        hits[s] = '0;
        for (int i = 0; i < MAX_KEPT; i++) begin
          earliest[s][i] = '0;
        end
      end
    endfunction

    function void set_kept(logic [NK_W-1:0] v);
      num_kept = v;
    endfunction

    function int pending();
      return want_mean.size();
    endfunction

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= MISMATCH_SHOWN) begin
        $display("mismatch at %0t: %s", $realtime, what);
      end
    endfunction

    // A full list only takes a time below its largest entry; the count advances until it saturates.
    function void insert_time(logic sd, logic [TIME_BITS-1:0] t);
      int filled;
      int last;
      int p;
      filled = (hits[sd] < MAX_KEPT) ? int'(hits[sd]) : MAX_KEPT;
      last   = (filled < MAX_KEPT) ? filled : MAX_KEPT - 1;
      if (filled == MAX_KEPT && t >= earliest[sd][MAX_KEPT-1]) begin
        last = MAX_KEPT;
      end
      if (last < MAX_KEPT) begin
        p = 0;
        while (p < last && earliest[sd][p] <= t) begin
          p++;
        end
        for (int i = last; i > p; i--) begin
          earliest[sd][i] = earliest[sd][i-1];
        end
        earliest[sd][p] = t;
      end
      if (hits[sd] != '1) begin
        hits[sd]++;
      end
    endfunction

    // Called for every accepted input beat.
    function void take_beat(logic op, logic sd, logic [IN_W-1:0] t);
      int          k;
      logic [63:0] sum;
      logic [63:0] quo;
      if (op == OP_HIT) begin
        insert_time(sd, TIME_BITS'(t));
      end else begin
        k = int'(num_kept);
        if (k < 1) begin
          k = 1;
        end
        if (k > MAX_KEPT) begin
          k = MAX_KEPT;
        end
        sum = '0;
        for (int i = 0; i < k; i++) begin
          sum += 64'(earliest[SIDE_RIGHT][i]) + 64'(earliest[SIDE_LEFT][i]);
        end
        quo = sum / 64'(2 * k);
        want_mean.push_back(quo[MEAN_W-1:0]);
        want_right.push_back(hits[SIDE_RIGHT]);
        want_left.push_back(hits[SIDE_LEFT]);
        clear_lists();
      end
    endfunction

    // Called for every accepted result beat.
    function void check_readout(logic [MEAN_W-1:0] mean, logic [CNT_W-1:0] rh,
                                logic [CNT_W-1:0] lh);
      logic [MEAN_W-1:0] em;
      logic [CNT_W-1:0]  er;
      logic [CNT_W-1:0]  el;
      if (want_mean.size() == 0) begin
        note_mismatch($sformatf("unexpected readout mean=%0d right=%0d left=%0d",
                                mean, rh, lh));
        return;
      end
      em = want_mean.pop_front();
      er = want_right.pop_front();
      el = want_left.pop_front();
      if (mean !== em) begin
        note_mismatch($sformatf("mean_time expected %0d got %0d", em, mean));
      end
      if (rh !== er) begin
        note_mismatch($sformatf("right_hits expected %0d got %0d", er, rh));
      end
      if (lh !== el) begin
        note_mismatch($sformatf("left_hits expected %0d got %0d", el, lh));
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              opcode_i;
  logic              side_i;
  logic [IN_W-1:0]   arrival_time_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [MEAN_W-1:0] mean_time_o;
  logic [CNT_W-1:0]  right_hits_o;
  logic [CNT_W-1:0]  left_hits_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [NK_W-1:0]   cfg_data_i;

  arrival_mean_board board;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  two_side_earliest_arrival_timer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .side_i         (side_i),
    .arrival_time_i (arrival_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_time_o    (mean_time_o),
    .right_hits_o   (right_hits_o),
    .left_hits_o    (left_hits_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Free-running clock.
  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watch every handshake at the rising edge and feed the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_readout(mean_time_o, right_hits_o, left_hits_o);
      end
      if (in_valid_i && !in_stall_o) begin
        board.take_beat(opcode_i, side_i, arrival_time_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        board.set_kept(cfg_data_i);
      end
    end
  end

  // Offer one input beat, after a random idle gap, and hold it until accepted.
  task automatic send_beat(input logic op, input logic sd, input logic [IN_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    side_i         <= sd;
    arrival_time_i <= t;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every readout has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (board.pending() != 0);
  endtask

  // Write num_kept once the block is idle.
  task automatic write_kept(input logic [NK_W-1:0] v);
    wait_for_results();
    repeat (READOUT_SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Arrival times: full range, small values that repeat, and the extremes.
  function automatic logic [IN_W-1:0] pick_time();
    int mode;
    mode = $urandom_range(99);
    if (mode < 45) begin
      return $urandom();
    end else if (mode < 70) begin
      return $urandom_range(15);
    end else if (mode < 85) begin
      return '1 - IN_W'($urandom_range(15));
    end else begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
  endfunction

  // Bursts of hits closed by a readout, with a few loose hits left at the end.
  task automatic run_random(input int n_items);
    int sent;
    int reads;
    int burst;
    sent  = 0;
    reads = 0;
    while (sent < n_items || reads < 12) begin
      burst = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 20);
      repeat (burst) begin
        send_beat(OP_HIT, 1'($urandom_range(1)), pick_time());
      end
      send_beat(OP_READ, 1'($urandom_range(1)), $urandom());
      sent  += burst + 1;
      reads++;
    end
    repeat ($urandom_range(0, 8)) begin
      send_beat(OP_HIT, 1'($urandom_range(1)), pick_time());
    end
  endtask

  // Main sequence.
  initial begin
    board          = new();
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_HIT;
    side_i         = SIDE_LEFT;
    arrival_time_i = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Readout of empty lists at the reset setting.
    send_beat(OP_READ, SIDE_RIGHT, '1);
    // Extreme times on both sides, and an equal pair.
    send_beat(OP_HIT, SIDE_RIGHT, '1);
    send_beat(OP_HIT, SIDE_LEFT, '1);
    send_beat(OP_HIT, SIDE_RIGHT, '0);
    send_beat(OP_HIT, SIDE_LEFT, '0);
    send_beat(OP_HIT, SIDE_RIGHT, 32'd5);
    send_beat(OP_HIT, SIDE_RIGHT, 32'd5);
    send_beat(OP_HIT, SIDE_LEFT, 32'd7);
    send_beat(OP_READ, SIDE_LEFT, '0);
    // A setting of zero counts as one.
    write_kept(NK_W'(0));
    send_beat(OP_HIT, SIDE_RIGHT, 32'd100);
    send_beat(OP_HIT, SIDE_LEFT, 32'd301);
    send_beat(OP_READ, SIDE_RIGHT, 32'h5555_5555);
    // A setting above the list depth, then a change between hits.
    write_kept(NK_W'(31));
    send_beat(OP_HIT, SIDE_LEFT, 32'd9);
    write_kept(NK_W'(1));
    send_beat(OP_HIT, SIDE_RIGHT, 32'd3);
    send_beat(OP_HIT, SIDE_RIGHT, '1);
    send_beat(OP_HIT, SIDE_LEFT, '1);
    send_beat(OP_READ, SIDE_LEFT, 32'hAAAA_AAAA);

    // Receiver holds off while readouts keep coming, so the input backs up.
    write_kept(NK_W'(16));
    hold_left = 400;
    repeat (4) begin
      repeat (5) begin
        send_beat(OP_HIT, 1'($urandom_range(1)), pick_time());
      end
      send_beat(OP_READ, 1'($urandom_range(1)), $urandom());
    end
    wait_for_results();

    // Random phases under different idling.
    write_kept(NK_W'(16));
    run_random(175);
    send_idle_pct  = 71;
    recv_stall_pct = 0;
    write_kept(NK_W'($urandom_range(2, 15)));
    run_random(175);
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    write_kept(NK_W'($urandom_range(17, 30)));
    run_random(175);
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    write_kept(NK_W'($urandom_range(0, 31)));
    run_random(175);

    wait_for_results();
    repeat (READOUT_SETTLE) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** two_side_earliest_arrival_timer_core: PASSED **");
    end else begin
      $display("** two_side_earliest_arrival_timer_core: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("** two_side_earliest_arrival_timer_core: FAILED **");
    $finish;
  end

endmodule
